// ----- rtl/dqs_pkg.sv -----
// Shared types and constants for the double-ended queue with search.
// No dependencies; imported by every module of the block.
package dqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CNT_W     = 5;

  localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP_BACK   = 3'd2;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [2:0] REQ_SEARCH     = 3'd4;
  localparam logic [2:0] REQ_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } dqs_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] removed_value;
    logic [CNT_W-1:0]   count;
  } dqs_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SRCH
  } dqs_state_t;

  typedef struct packed {
    logic       cap;
    logic       push_wr;
    logic       rd_pop;
    logic       pop_do;
    logic       srch_first;
    logic       srch_next;
    logic       clr;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_found;
    logic       emit_use_rd;
  } dqs_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       full;
    logic       empty;
    logic       match;
    logic       last;
    logic       out_free;
  } dqs_sts_t;

endpackage

// ----- rtl/deque_with_search_top.sv -----
// Top level of the bounded double-ended queue with search.
// Depends on dqs_pkg, dqs_ctrl and dqs_dp.
//
// Bounded deque of signed 32-bit values held in a DEPTH-entry ring buffer;
// each request (push back/front, pop back/front, search, clear) returns one
// result with status, found flag, popped value and the remaining count.
// One request is in work at a time. Push, clear and unknown codes go from
// acceptance through the execute state to the result, pops go through the
// execute and pop states, and a search walks from the front entry until the
// first match or until all counted entries are read. The search walk uses
// the single registered memory read port, which walks one entry per
// cycle. A finished result waits in the output register while the next
// request is accepted.
module deque_with_search_top
  import dqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dqs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dqs_out_t out_data
);

  dqs_cmd_t cmd;
  dqs_sts_t sts;

  dqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- rtl/dqs_ctrl.sv -----
// Controller state machine for the double-ended queue with search.
// Depends on dqs_pkg; drives dqs_dp through command and status structs.
module dqs_ctrl
  import dqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dqs_sts_t sts,
  output dqs_cmd_t cmd
);

  dqs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.req_type)
          REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              if (sts.full) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.push_wr     = 1'b1;
                cmd.emit_status = ST_OK;
              end
              state_nxt = S_IDLE;
            end
          end
          REQ_POP_BACK, REQ_POP_FRONT: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_EMPTY;
                state_nxt       = S_IDLE;
              end
            end else begin
              cmd.rd_pop = 1'b1;
              state_nxt  = S_POP;
            end
          end
          REQ_SEARCH: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_OK;
                state_nxt       = S_IDLE;
              end
            end else begin
              cmd.srch_first = 1'b1;
              state_nxt      = S_SRCH;
            end
          end
          REQ_CLEAR: begin
            if (sts.out_free) begin
              cmd.clr         = 1'b1;
              cmd.emit        = 1'b1;
              cmd.emit_status = sts.empty ? ST_EMPTY : ST_OK;
              state_nxt       = S_IDLE;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_OK;
              state_nxt       = S_IDLE;
            end
          end
        endcase
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd.pop_do      = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_use_rd = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_SRCH: begin
        priority if (sts.match || sts.last) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_OK;
            cmd.emit_found  = sts.match;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.srch_next = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/dqs_dp.sv -----
// Datapath for the double-ended queue: ring buffer memory, pointers,
// search walker and result register. Depends on dqs_pkg; driven by dqs_ctrl.
module dqs_dp
  import dqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  dqs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dqs_out_t out_data,
  input  dqs_cmd_t cmd,
  output dqs_sts_t sts
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int XW = CW + CNT_W;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data_r;
  logic [2:0]    req_r;
  logic [31:0]   val_r;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] idx_r;
  logic [AW-1:0] rd_addr_r, rd_addr;
  logic          out_valid_r;
  dqs_out_t      out_data_r;

  logic [SW-1:0] sum_back, sum_last;
  logic [AW-1:0] slot_back, slot_last, front_dec, front_inc, rd_inc;
  logic [AW-1:0] wr_addr;
  logic [XW-1:0] occ_ext;

  assign sum_back  = {1'b0, front_r} + SW'(occ_r);
  assign sum_last  = sum_back - SW'(1);
  assign slot_back = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
  assign slot_last = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign rd_inc    = (rd_addr_r == AW'(DEPTH - 1)) ? '0 : rd_addr_r + AW'(1);
  assign wr_addr   = (req_r == REQ_PUSH_FRONT) ? front_dec : slot_back;

  always_comb begin
    rd_addr = rd_addr_r;
    priority if (cmd.rd_pop) begin
      rd_addr = (req_r == REQ_POP_FRONT) ? front_r : slot_last;
    end else if (cmd.srch_first) begin
      rd_addr = front_r;
    end else if (cmd.srch_next) begin
      rd_addr = rd_inc;
    end
  end

  always_comb begin
    front_nxt = front_r;
    occ_nxt   = occ_r;
    priority if (cmd.clr) begin
      front_nxt = '0;
      occ_nxt   = '0;
    end else if (cmd.push_wr) begin
      occ_nxt = occ_r + CW'(1);
      if (req_r == REQ_PUSH_FRONT) begin
        front_nxt = front_dec;
      end
    end else if (cmd.pop_do) begin
      occ_nxt = occ_r - CW'(1);
      if (req_r == REQ_POP_FRONT) begin
        front_nxt = front_inc;
      end
    end
  end

  assign occ_ext = {{CNT_W{1'b0}}, occ_nxt};

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[wr_addr] <= val_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_data.req_type;
      val_r <= in_data.value;
    end
    if (cmd.srch_first) begin
      idx_r <= '0;
    end else if (cmd.srch_next) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.emit) begin
      out_data_r.status        <= cmd.emit_status;
      out_data_r.found         <= cmd.emit_found;
      out_data_r.removed_value <= cmd.emit_use_rd ? rd_data_r : '0;
      out_data_r.count         <= occ_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      rd_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r   <= front_nxt;
      occ_r     <= occ_nxt;
      rd_addr_r <= rd_addr;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.req_type = req_r;
  assign sts.full     = (occ_r == CW'(DEPTH));
  assign sts.empty    = (occ_r == '0);
  assign sts.match    = (rd_data_r == val_r);
  assign sts.last     = ((idx_r + CW'(1)) == occ_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
